// File: hw/rtl/dtdy_pkg.sv
// Package for the date-to-decimal-year pipeline: word types, timing constants
// and the month offset table. No dependencies; imported by date_to_decimal_year and tb.
package dtdy_pkg;

    // Fraction precision and the layout of the long division stages.
    localparam int FRACTION_BITS      = 32;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         =
        (FRACTION_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    // Stages ahead of the divider: decode, leap test, day fix, day scale, sum.
    localparam int FRONT_STAGES = 5;
    // The carry stage and the division stages follow them.
    localparam int NUM_STAGES   = FRONT_STAGES + 1 + DIV_STAGES;

    // Field widths.
    localparam int YEAR_W = 14;
    localparam int DOY_W  = 9;
    localparam int TOD_W  = 27;
    localparam int REM_W  = 35;
    localparam int FRAC_OUT_W = 32;

    // Millisecond constants.
    localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    // Length of a common and of a leap year in milliseconds.
    localparam logic [REM_W-1:0] DENOM_COMMON = 35'd31536000000;
    localparam logic [REM_W-1:0] DENOM_LEAP   = 35'd31622400000;

    // Reciprocal of 25 scaled by 2^17; exact quotient for every 14-bit year.
    localparam logic [12:0] RECIP_25       = 13'd5243;
    localparam int          RECIP_25_SHIFT = 17;
    localparam logic [YEAR_W-1:0] TWENTY_FIVE = 14'd25;

    // Input word.
    typedef struct packed {
        logic [13:0] year_number;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [15:0] second_millis;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [13:0] whole_year;
        logic [31:0] year_fraction;
        logic [8:0]  day_index;
    } out_word_t;

    // Word carried through the division stages.
    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic [DOY_W-1:0]         doy;
        logic                     leap;
        logic [REM_W-1:0]         rem;
        logic [FRACTION_BITS-1:0] frac;
    } div_word_t;

    // Day offset at the start of each month; other codes read as January.
    function automatic logic [DOY_W-1:0] month_offset(input logic [3:0] month);
        logic [DOY_W-1:0] offset;
        unique case (month)
            4'd2:    offset = 9'd31;
            4'd3:    offset = 9'd59;
            4'd4:    offset = 9'd90;
            4'd5:    offset = 9'd120;
            4'd6:    offset = 9'd151;
            4'd7:    offset = 9'd181;
            4'd8:    offset = 9'd212;
            4'd9:    offset = 9'd243;
            4'd10:   offset = 9'd273;
            4'd11:   offset = 9'd304;
            4'd12:   offset = 9'd334;
            default: offset = 9'd0;
        endcase
        return offset;
    endfunction

endpackage

// File: hw/rtl/date_to_decimal_year.sv
// Top level of the date-to-decimal-year converter: a fully pipelined datapath
// with a bubble-collapsing valid/ready chain. Depends on dtdy_pkg.

// The block takes one date and time word per clock while s_ready is high and
// returns one result word per input, in order, through its NUM_STAGES stages:
// five stages decode the date, test the leap year and form the elapsed
// milliseconds, one stage folds a time past year end into the year,
// and the rest are a restoring long divider that settles two fraction bits per
// stage. Each stage holds when the stage after it is full and stalled, so
// s_ready drops only when every stage holds a word. Months outside 1..12 are
// read as January, a day of zero as day one, and the fraction is the floor of
// the elapsed share of the year in units of 2^-32.
module date_to_decimal_year
    import dtdy_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // Valid bit per stage and the enable chain that collapses bubbles.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_in;
    logic [NUM_STAGES:0]   stage_en;

    assign stage_en[NUM_STAGES] = m_ready;
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_enable
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign valid_in = {valid_reg[NUM_STAGES-2:0], s_valid};
    assign s_ready  = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    // Stage A: split the date, start the divide-by-25 test, scale the time.
    logic [YEAR_W-1:0] year_a_reg;
    logic              leap4_a_reg;
    logic              leap16_a_reg;
    logic [9:0]        q25_a_reg;
    logic [DOY_W-1:0]  base_a_reg;
    logic [4:0]        daym1_a_reg;
    logic              after_feb_a_reg;
    logic [26:0]       hour_ms_a_reg;
    logic [21:0]       minute_ms_a_reg;
    logic [15:0]       msec_a_reg;

    logic [26:0] q25_prod_next;
    logic [4:0]  daym1_next;

    assign q25_prod_next = 27'(s_data.year_number) * 27'(RECIP_25);
    assign daym1_next    = (s_data.day_of_month == 5'd0) ? 5'd0
                         : s_data.day_of_month - 5'd1;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            year_a_reg      <= s_data.year_number;
            leap4_a_reg     <= (s_data.year_number[1:0] == 2'd0);
            leap16_a_reg    <= (s_data.year_number[3:0] == 4'd0);
            q25_a_reg       <= q25_prod_next[RECIP_25_SHIFT +: 10];
            base_a_reg      <= month_offset(s_data.month_number);
            daym1_a_reg     <= daym1_next;
            after_feb_a_reg <= (s_data.month_number >= 4'd3)
                            && (s_data.month_number <= 4'd12);
            hour_ms_a_reg   <= 27'(s_data.hour_of_day) * 27'(MS_PER_HOUR);
            minute_ms_a_reg <= 22'(s_data.minute_of_hour) * 22'(MS_PER_MINUTE);
            msec_a_reg      <= s_data.second_millis;
        end
    end

    // Stage B: finish the divide-by-25 test, day before leap fix, time of day.
    logic [YEAR_W-1:0] year_b_reg;
    logic              leap4_b_reg;
    logic              leap16_b_reg;
    logic              div25_b_reg;
    logic [DOY_W-1:0]  doy_pre_b_reg;
    logic              after_feb_b_reg;
    logic [TOD_W-1:0]  tod_b_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            year_b_reg      <= year_a_reg;
            leap4_b_reg     <= leap4_a_reg;
            leap16_b_reg    <= leap16_a_reg;
            div25_b_reg     <= (year_a_reg == 14'(q25_a_reg) * TWENTY_FIVE);
            doy_pre_b_reg   <= base_a_reg + 9'(daym1_a_reg);
            after_feb_b_reg <= after_feb_a_reg;
            tod_b_reg       <= hour_ms_a_reg + 27'(minute_ms_a_reg)
                             + 27'(msec_a_reg);
        end
    end

    // Stage C: Gregorian leap rule and the extra day after February.
    logic [YEAR_W-1:0] year_c_reg;
    logic              leap_c_reg;
    logic [DOY_W-1:0]  doy_c_reg;
    logic [TOD_W-1:0]  tod_c_reg;
    logic              leap_next;

    assign leap_next = leap4_b_reg && (!div25_b_reg || leap16_b_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            year_c_reg <= year_b_reg;
            leap_c_reg <= leap_next;
            doy_c_reg  <= doy_pre_b_reg + 9'(leap_next && after_feb_b_reg);
            tod_c_reg  <= tod_b_reg;
        end
    end

    // Stage D: whole days in milliseconds.
    logic [YEAR_W-1:0] year_d_reg;
    logic              leap_d_reg;
    logic [DOY_W-1:0]  doy_d_reg;
    logic [TOD_W-1:0]  tod_d_reg;
    logic [REM_W-1:0]  day_ms_d_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            year_d_reg   <= year_c_reg;
            leap_d_reg   <= leap_c_reg;
            doy_d_reg    <= doy_c_reg;
            tod_d_reg    <= tod_c_reg;
            day_ms_d_reg <= 35'(doy_c_reg) * 35'(MS_PER_DAY);
        end
    end

    // Stage E: elapsed milliseconds since the start of the year.
    logic [YEAR_W-1:0] year_e_reg;
    logic              leap_e_reg;
    logic [DOY_W-1:0]  doy_e_reg;
    logic [REM_W-1:0]  total_e_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            year_e_reg  <= year_d_reg;
            leap_e_reg  <= leap_d_reg;
            doy_e_reg   <= doy_d_reg;
            total_e_reg <= day_ms_d_reg + 35'(tod_d_reg);
        end
    end

    // Carry stage: a time at or past year end moves into the next year.
    // The total stays below twice the year length, so one subtract suffices.
    div_word_t        div_reg  [DIV_STAGES+1];
    div_word_t        div_next [DIV_STAGES+1];
    logic [REM_W-1:0] carry_denom;
    logic             carry_ge;

    assign carry_denom = leap_e_reg ? DENOM_LEAP : DENOM_COMMON;
    assign carry_ge    = (total_e_reg >= carry_denom);

    // Carry stage word, then the division stages: restoring steps with
    // DIV_BITS_PER_STAGE quotient bits each.
    always_comb begin
        div_word_t        cur;
        logic [REM_W:0]   shifted;
        logic [REM_W-1:0] den;
        logic             take;
        div_next[0].year = year_e_reg + 14'(carry_ge);
        div_next[0].doy  = doy_e_reg;
        div_next[0].leap = leap_e_reg;
        div_next[0].rem  = carry_ge ? total_e_reg - carry_denom : total_e_reg;
        div_next[0].frac = '0;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            cur = div_reg[s-1];
            den = cur.leap ? DENOM_LEAP : DENOM_COMMON;
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                if ((s - 1) * DIV_BITS_PER_STAGE + j < FRACTION_BITS) begin
                    shifted  = {cur.rem, 1'b0};
                    take     = (shifted >= {1'b0, den});
                    cur.rem  = take ? REM_W'(shifted - {1'b0, den}) : REM_W'(shifted);
                    cur.frac = {cur.frac[FRACTION_BITS-2:0], take};
                end
            end
            div_next[s] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s <= DIV_STAGES; s++) begin
            if (stage_en[FRONT_STAGES + s]) begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // Result word from the last division stage.
    assign m_valid              = valid_reg[NUM_STAGES-1];
    assign m_data.whole_year    = div_reg[DIV_STAGES].year;
    assign m_data.year_fraction = FRAC_OUT_W'(div_reg[DIV_STAGES].frac);
    assign m_data.day_index     = div_reg[DIV_STAGES].doy;

    // The day of year never passes the last day of a leap year.
    a_day_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.day_index <= 9'd365))
        else $error("day_index beyond the end of a leap year");

    // After the carry stage the remainder is below the year length.
    a_carry_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[FRONT_STAGES] |->
            (div_reg[0].rem < (div_reg[0].leap ? DENOM_LEAP : DENOM_COMMON)))
        else $error("remainder not reduced below the year length");

    // Input back-pressure appears only when every stage is full.
    a_full_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("s_ready low while the pipeline has a bubble");

endmodule

// File: dv/tb.sv
// Testbench for date_to_decimal_year: random and directed dates with random
// idling on both channels, checked against a local predictor.
// Depends on dtdy_pkg and the date_to_decimal_year RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtdy_pkg::*;

    // A run with no handshake for this many cycles is hung. This is far above
    // the long receiver hold-off and any plausible run of random stalls.
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_WORDS  = 133;

    // Tracks the expected conversion of each accepted date, oldest first.
    class date_scoreboard;
        out_word_t pending_years[$];
        int        errors = 0;

        // Decimal year of one date: whole year, fraction of the year and
        // zero-based day of year.
        static function out_word_t predict_decimal_year(in_word_t d);
            int unsigned starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212,
                                        243, 273, 304, 334};
            logic [63:0] yr;
            logic [63:0] mon;
            logic [63:0] day;
            logic [63:0] doy;
            logic [63:0] elapsed_ms;
            logic [63:0] year_ms;
            logic [63:0] carry;
            logic [63:0] rem;
            logic [95:0] scaled;
            logic [95:0] frac;
            logic        is_leap;
            out_word_t   r;
            yr  = 64'(d.year_number);
            mon = 64'(d.month_number);
            day = 64'(d.day_of_month);
            is_leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            // Out-of-range months read as January, day zero as day one.
            if (mon < 1 || mon > 12) begin
                mon = 1;
            end
            if (day == 0) begin
                day = 1;
            end
            doy = 64'(starts[mon - 1]) + day - 1;
            if (is_leap && mon > 2) begin
                doy = doy + 1;
            end
            elapsed_ms = doy * 64'd86400000 + 64'(d.hour_of_day) * 64'd3600000
                       + 64'(d.minute_of_hour) * 64'd60000 + 64'(d.second_millis);
            year_ms = (is_leap ? 64'd366 : 64'd365) * 64'd86400000;
            // Time that runs past the end of the year carries into the year.
            carry = elapsed_ms / year_ms;
            rem   = elapsed_ms % year_ms;
            scaled = {rem, 32'h0};
            frac   = scaled / {32'h0, year_ms};
            r.whole_year    = 14'(yr + carry);
            r.year_fraction = frac[31:0];
            r.day_index     = doy[8:0];
            return r;
        endfunction

        function void note_date(in_word_t d);
            pending_years.push_back(predict_decimal_year(d));
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending_years.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending_years.pop_front();
            if (got.whole_year !== want.whole_year) begin
                $display("%0t: whole_year expected %0d got %0d", $time,
                         want.whole_year, got.whole_year);
                errors++;
            end
            if (got.year_fraction !== want.year_fraction) begin
                $display("%0t: year_fraction expected %h got %h", $time,
                         want.year_fraction, got.year_fraction);
                errors++;
            end
            if (got.day_index !== want.day_index) begin
                $display("%0t: day_index expected %0d got %0d", $time,
                         want.day_index, got.day_index);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int  send_idle_pct = 11;
    int  recv_idle_pct = 55;
    bit  hold_request  = 1'b0;

    date_scoreboard sb = new;

    date_to_decimal_year DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one date word and hold it until the block takes it.
    task automatic send_date(in_word_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly plausible dates, with leap and century years favored; the rest
    // is noise across the full width of every field.
    function automatic in_word_t random_date();
        in_word_t    d;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            d.year_number    = 14'($urandom);
            d.month_number   = 4'($urandom);
            d.day_of_month   = 5'($urandom);
            d.hour_of_day    = 5'($urandom);
            d.minute_of_hour = 6'($urandom);
            d.second_millis  = 16'($urandom);
        end else begin
            case ($urandom_range(3))
                0:       d.year_number = 14'($urandom_range(0, 99) * 100);
                1:       d.year_number = 14'($urandom_range(0, 2499) * 4);
                default: d.year_number = 14'($urandom_range(0, 9999));
            endcase
            d.month_number   = 4'($urandom_range(1, 12));
            d.day_of_month   = 5'($urandom_range(1, 31));
            d.hour_of_day    = 5'($urandom_range(0, 23));
            d.minute_of_hour = 6'($urandom_range(0, 59));
            d.second_millis  = 16'($urandom_range(0, 60999));
            // Push some dates to the last hour of the year.
            if (pick < 25) begin
                d.month_number = 4'd12;
                d.day_of_month = 5'd31;
                d.hour_of_day  = 5'd23;
            end
        end
        return d;
    endfunction

    // Receiver: random back-pressure, and one long hold-off when requested.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Handshake monitor: values are sampled as they stood before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_date(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    // Main sequence: reset, directed dates, then three phases of random dates.
    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Year boundaries, leap rules, odd months and days, field extremes.
        send_date(in_word_t'{14'd0,     4'd1,  5'd1,  5'd0,  6'd0,  16'd0});
        send_date(in_word_t'{14'd0,     4'd0,  5'd0,  5'd0,  6'd0,  16'd0});
        send_date(in_word_t'{14'd0,     4'd2,  5'd29, 5'd6,  6'd0,  16'd0});
        send_date(in_word_t'{14'd9999,  4'd12, 5'd31, 5'd23, 6'd59, 16'd60999});
        send_date(in_word_t'{14'd2000,  4'd3,  5'd1,  5'd0,  6'd0,  16'd0});
        send_date(in_word_t'{14'd1900,  4'd3,  5'd1,  5'd0,  6'd0,  16'd0});
        send_date(in_word_t'{14'd2100,  4'd3,  5'd1,  5'd12, 6'd0,  16'd0});
        send_date(in_word_t'{14'd1600,  4'd7,  5'd4,  5'd18, 6'd45, 16'd15000});
        send_date(in_word_t'{14'd2024,  4'd2,  5'd29, 5'd12, 6'd30, 16'd30000});
        send_date(in_word_t'{14'd2023,  4'd2,  5'd28, 5'd23, 6'd59, 16'd59999});
        send_date(in_word_t'{14'd2024,  4'd12, 5'd31, 5'd23, 6'd59, 16'd60999});
        send_date(in_word_t'{14'd2000,  4'd12, 5'd31, 5'd23, 6'd59, 16'd59999});
        send_date(in_word_t'{14'd2021,  4'd0,  5'd15, 5'd8,  6'd20, 16'd1000});
        send_date(in_word_t'{14'd2021,  4'd13, 5'd15, 5'd8,  6'd20, 16'd1000});
        send_date(in_word_t'{14'd2021,  4'd15, 5'd15, 5'd8,  6'd20, 16'd1000});
        send_date(in_word_t'{14'd2022,  4'd6,  5'd0,  5'd3,  6'd7,  16'd500});
        // Exactly one year of elapsed time in a leap and a common year, then well past the end of the year.
        send_date(in_word_t'{14'd2024,  4'd12, 5'd31, 5'd24, 6'd0,  16'd0});
        send_date(in_word_t'{14'd2023,  4'd12, 5'd31, 5'd24, 6'd0,  16'd0});
        send_date(in_word_t'{14'd2023,  4'd12, 5'd31, 5'd31, 6'd63, 16'd65535});
        // The carry wraps the top year around to zero.
        send_date(in_word_t'{14'd16383, 4'd12, 5'd31, 5'd31, 6'd63, 16'd65535});
        send_date(in_word_t'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535});

        for (k = 0; k < PHASE_WORDS; k++) begin
            send_date(random_date());
        end

        send_idle_pct = 55;
        recv_idle_pct = 11;
        for (k = 0; k < PHASE_WORDS; k++) begin
            send_date(random_date());
        end

        // No idling; the receiver first holds off so the pipeline fills up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (k = 0; k < PHASE_WORDS; k++) begin
            send_date(random_date());
        end
        s_valid <= 1'b0;

        while (sb.pending_years.size() != 0) @(posedge aclk);
        repeat (2 * NUM_STAGES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dtdy_pkg.sv
hw/rtl/date_to_decimal_year.sv
dv/tb.sv
